/* rtl/matrix3x3_inverse_determinant_macros.svh */
// Assertion macros shared by the checker of the 3x3 inverse block.
`ifndef MATRIX3X3_INVERSE_DETERMINANT_MACROS_SVH
`define MATRIX3X3_INVERSE_DETERMINANT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define MI3_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mi3 assertion failed");

// Implication whose consequent carries its own delay or sampled-value terms.
`define MI3_ASSERT_SEQ(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("mi3 timing assertion failed");

`endif

/* rtl/mi3_pkg.sv */
// Types, widths and helpers shared by the 3x3 inverse modules.
`default_nettype none
package mi3_pkg;

   localparam int ELEM_W  = 32;
   localparam int COF_W   = 65;
   localparam int DET_W   = 98;
   localparam int DMAG_W  = 96;
   localparam int DIV_W   = 130;
   localparam int QUO_W   = 32;
   localparam int LANES   = 9;

   localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a00;
      logic signed [ELEM_W-1:0] a01;
      logic signed [ELEM_W-1:0] a02;
      logic signed [ELEM_W-1:0] a10;
      logic signed [ELEM_W-1:0] a11;
      logic signed [ELEM_W-1:0] a12;
      logic signed [ELEM_W-1:0] a20;
      logic signed [ELEM_W-1:0] a21;
      logic signed [ELEM_W-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] inv00;
      logic signed [ELEM_W-1:0] inv01;
      logic signed [ELEM_W-1:0] inv02;
      logic signed [ELEM_W-1:0] inv10;
      logic signed [ELEM_W-1:0] inv11;
      logic signed [ELEM_W-1:0] inv12;
      logic signed [ELEM_W-1:0] inv20;
      logic signed [ELEM_W-1:0] inv21;
      logic signed [ELEM_W-1:0] inv22;
      logic signed [ELEM_W-1:0] det_value;
      logic                     singular;
   } rsp_type;

   typedef struct packed {
      logic              dneg;
      logic              dzero;
      logic [DMAG_W-1:0] dmag;
   } det_info_type;

   typedef struct packed {
      logic             neg;
      logic             big;
      logic [QUO_W-1:0] q;
   } lane_out_type;

   typedef struct packed {
      logic             singular;
      logic [QUO_W-1:0] value;
   } det_out_type;

   // Apply sign and saturate a rounded magnitude to 32 bits.
   function automatic logic [QUO_W-1:0] sat_q(input logic neg, input logic big,
                                              input logic [QUO_W-1:0] q);
      logic [QUO_W-1:0] r;
      if (!neg) begin
         r = (big || q[QUO_W-1]) ? SAT_POS : q;
      end else begin
         r = (big || (q[QUO_W-1] && (|q[QUO_W-2:0]))) ? SAT_NEG : (~q + 32'd1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/matrix3x3_inverse_determinant.sv */
// Top level of the pipelined 3x3 fixed-point matrix inverse and determinant.
//
//  channel  ports                     direction  word
//  request  start, busy, req_word     in         nine Q16.16 elements, row-major
//  response rsp_strobe, rsp_word      out        nine inverse entries, det, singular
//
// A word is taken on every clock edge where start is high and busy is low; busy
// stays low, so one matrix enters per cycle. Each result appears for one cycle,
// marked by rsp_strobe, after passing through the input register, the cofactor
// products, the determinant partial products and sums, the division lanes with
// 32 restoring quotient stages, and the merge register.
// Reset (synchronous, active high) clears the valid pipeline only; no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module matrix3x3_inverse_determinant #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mi3_pkg::req_type req_word,
   output logic             rsp_strobe,
   output mi3_pkg::rsp_type rsp_word
);
   import mi3_pkg::*;

   localparam int LAT      = 42;
   localparam int COF_DLY  = 4;
   localparam int A_DLY    = 2;
   localparam int LANE_LAT = 34;
   localparam int DR_W     = DMAG_W + 1;

   logic                     accept;
   logic [LAT-1:0]           vld_ff, vld_in;
   req_type                  req_ff;
   logic signed [ELEM_W-1:0] elem [3][3];
   logic signed [COF_W-1:0]  cof [3][3];
   logic signed [COF_W-1:0]  cof_pipe_ff [COF_DLY][3][3];
   logic signed [ELEM_W-1:0] a_pipe_ff [A_DLY][3];
   logic signed [COF_W-1:0]  cof_row [3];
   det_info_type             det_info;
   lane_out_type             lane_out [3][3];
   logic [DR_W-1:0]          dround;
   det_out_type              det_out_in;
   det_out_type              det_pipe_ff [LANE_LAT];
   logic [QUO_W-1:0]         inv_val [3][3];
   rsp_type                  rsp_ff, rsp_in;

   // Never hold off the requester: every stage advances each cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
   end

   assign elem[0][0] = req_ff.a00;
   assign elem[0][1] = req_ff.a01;
   assign elem[0][2] = req_ff.a02;
   assign elem[1][0] = req_ff.a10;
   assign elem[1][1] = req_ff.a11;
   assign elem[1][2] = req_ff.a12;
   assign elem[2][0] = req_ff.a20;
   assign elem[2][1] = req_ff.a21;
   assign elem[2][2] = req_ff.a22;

   // Nine cofactor lanes; each takes the rows and columns other than its own.
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R0 = (i == 0) ? 1 : 0;
         localparam int R1 = (i == 2) ? 1 : 2;
         localparam int C0 = (j == 0) ? 1 : 0;
         localparam int C1 = (j == 2) ? 1 : 2;
         mi3_minor #(.NEGATE(((i + j) % 2) == 1)) u_minor (
            .clock (clock),
            .a_p   (elem[R0][C0]),
            .a_q   (elem[R0][C1]),
            .a_r   (elem[R1][C0]),
            .a_s   (elem[R1][C1]),
            .cof   (cof[i][j])
         );
      end
   end

   // Hold cofactors and first-row elements until the determinant catches up.
   always_ff @(posedge clock) begin
      cof_pipe_ff[0] <= cof;
      for (int k = 1; k < COF_DLY; k++) begin
         cof_pipe_ff[k] <= cof_pipe_ff[k-1];
      end
      for (int j = 0; j < 3; j++) begin
         a_pipe_ff[0][j] <= elem[0][j];
      end
      for (int k = 1; k < A_DLY; k++) begin
         a_pipe_ff[k] <= a_pipe_ff[k-1];
      end
   end

   assign cof_row[0] = cof[0][0];
   assign cof_row[1] = cof[0][1];
   assign cof_row[2] = cof[0][2];

   mi3_det u_det (
      .clock    (clock),
      .cof_row  (cof_row),
      .a_row    (a_pipe_ff[A_DLY-1]),
      .det_info (det_info)
   );

   // Entry (i, j) of the inverse divides cofactor (j, i): the adjugate.
   for (genvar i = 0; i < 3; i++) begin : g_lane_row
      for (genvar j = 0; j < 3; j++) begin : g_lane_col
         mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clock    (clock),
            .cof      (cof_pipe_ff[COF_DLY-1][j][i]),
            .det_info (det_info),
            .result   (lane_out[i][j])
         );
      end
   end

   // Round the determinant back to FRAC_BITS fraction bits, then delay it.
   assign dround = (DR_W'(det_info.dmag) + (DR_W'(1) << (2*FRAC_BITS - 1)))
                   >> (2*FRAC_BITS);

   always_comb begin
      det_out_in.singular = det_info.dzero;
      det_out_in.value    = sat_q(det_info.dneg, |dround[DR_W-1:QUO_W],
                                  dround[QUO_W-1:0]);
   end

   always_ff @(posedge clock) begin
      det_pipe_ff[0] <= det_out_in;
      for (int k = 1; k < LANE_LAT; k++) begin
         det_pipe_ff[k] <= det_pipe_ff[k-1];
      end
   end

   // Merge: saturate each lane, drop everything to zero on a singular matrix.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            inv_val[i][j] = det_pipe_ff[LANE_LAT-1].singular ? '0 :
                            sat_q(lane_out[i][j].neg, lane_out[i][j].big,
                                  lane_out[i][j].q);
         end
      end
      rsp_in.inv00     = inv_val[0][0];
      rsp_in.inv01     = inv_val[0][1];
      rsp_in.inv02     = inv_val[0][2];
      rsp_in.inv10     = inv_val[1][0];
      rsp_in.inv11     = inv_val[1][1];
      rsp_in.inv12     = inv_val[1][2];
      rsp_in.inv20     = inv_val[2][0];
      rsp_in.inv21     = inv_val[2][1];
      rsp_in.inv22     = inv_val[2][2];
      rsp_in.det_value = det_pipe_ff[LANE_LAT-1].value;
      rsp_in.singular  = det_pipe_ff[LANE_LAT-1].singular;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[LAT-1];
   assign rsp_word   = rsp_ff;
endmodule
`default_nettype wire

/* rtl/mi3_minor.sv */
// One cofactor lane: a 2x2 minor with its checkerboard sign.
`default_nettype none
module mi3_minor #(
   parameter bit NEGATE = 1'b0
) (
   input  logic                              clock,
   input  logic signed [mi3_pkg::ELEM_W-1:0] a_p,
   input  logic signed [mi3_pkg::ELEM_W-1:0] a_q,
   input  logic signed [mi3_pkg::ELEM_W-1:0] a_r,
   input  logic signed [mi3_pkg::ELEM_W-1:0] a_s,
   output logic signed [mi3_pkg::COF_W-1:0]  cof
);
   import mi3_pkg::*;

   logic signed [2*ELEM_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [COF_W-1:0]    cof_ff, cof_in;

   assign p1_in = a_p * a_s;
   assign p2_in = a_q * a_r;
   assign cof_in = NEGATE ? (COF_W'(p2_ff) - COF_W'(p1_ff))
                          : (COF_W'(p1_ff) - COF_W'(p2_ff));

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      cof_ff <= cof_in;
   end

   assign cof = cof_ff;
endmodule
`default_nettype wire

/* rtl/mi3_det.sv */
// Determinant by first-row expansion, split into 33x32 partial products.
`default_nettype none
module mi3_det (
   input  logic                              clock,
   input  logic signed [mi3_pkg::COF_W-1:0]  cof_row [3],
   input  logic signed [mi3_pkg::ELEM_W-1:0] a_row [3],
   output mi3_pkg::det_info_type             det_info
);
   import mi3_pkg::*;

   logic signed [COF_W-1:0] pl_ff [3];
   logic signed [COF_W-1:0] ph_ff [3];
   logic signed [DET_W-1:0] term_ff [3];
   logic signed [DET_W-1:0] det_ff, det_in;
   logic [DET_W-1:0]        dabs;
   det_info_type            info_ff, info_in;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         pl_ff[j]   <= $signed({1'b0, cof_row[j][31:0]}) * a_row[j];
         ph_ff[j]   <= $signed(cof_row[j][COF_W-1:32]) * a_row[j];
         term_ff[j] <= (DET_W'(ph_ff[j]) <<< 32) + DET_W'(pl_ff[j]);
      end
      det_ff  <= det_in;
      info_ff <= info_in;
   end

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];
   assign dabs   = det_ff[DET_W-1] ? (~det_ff + 1'b1) : det_ff;

   always_comb begin
      info_in.dneg  = det_ff[DET_W-1];
      info_in.dzero = (det_ff == '0);
      info_in.dmag  = dabs[DMAG_W-1:0];
   end

   assign det_info = info_ff;
endmodule
`default_nettype wire

/* rtl/mi3_div_lane.sv */
// Division lane: rounded cofactor/determinant quotient, one bit per stage.
`default_nettype none
module mi3_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic signed [mi3_pkg::COF_W-1:0] cof,
   input  mi3_pkg::det_info_type            det_info,
   output mi3_pkg::lane_out_type            result
);
   import mi3_pkg::*;

   localparam int SHIFT = 2*FRAC_BITS + 1;
   // Wide enough for the shifted cofactor and for the full determinant magnitude.
   localparam int NUM_W = (2*FRAC_BITS + 66 > DMAG_W + 2) ? 2*FRAC_BITS + 66 : DMAG_W + 2;
   localparam int DEN_W = DMAG_W + 1;

   logic [COF_W-1:0] cabs;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] dena_ff, dena_in;
   logic             nega_ff, nega_in;

   logic [DIV_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             big_ff [QUO_W+1];
   logic             big_in;

   // Round to nearest: (|c| * 2^(2F+1) + |det|) / (2 |det|).
   assign cabs    = cof[COF_W-1] ? (~cof + 1'b1) : cof;
   assign num_in  = (NUM_W'(cabs[63:0]) << SHIFT) + NUM_W'(det_info.dmag);
   assign dena_in = {det_info.dmag, 1'b0};
   assign nega_in = cof[COF_W-1] ^ det_info.dneg;
   assign big_in  = DIV_W'(num_ff) >= (DIV_W'(dena_ff) << QUO_W);

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      dena_ff   <= dena_in;
      nega_ff   <= nega_in;
      rem_ff[0] <= DIV_W'(num_ff);
      den_ff[0] <= dena_ff;
      quo_ff[0] <= '0;
      neg_ff[0] <= nega_ff;
      big_ff[0] <= big_in;
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - 1 - s;
      logic [DIV_W-1:0] dsh;
      logic [DIV_W:0]   diff;
      logic             ge;

      assign dsh  = DIV_W'(den_ff[s]) << K;
      assign diff = {1'b0, rem_ff[s]} - {1'b0, dsh};
      assign ge   = ~diff[DIV_W];

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= ge ? diff[DIV_W-1:0] : rem_ff[s];
         quo_ff[s+1] <= quo_ff[s] | (QUO_W'(ge) << K);
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         big_ff[s+1] <= big_ff[s];
      end
   end

   always_comb begin
      result.neg = neg_ff[QUO_W];
      result.big = big_ff[QUO_W];
      result.q   = quo_ff[QUO_W];
   end
endmodule
`default_nettype wire

/* rtl/mi3_checker.sv */
// Port-level checker for the 3x3 inverse block, with its bind.
`default_nettype none
`include "matrix3x3_inverse_determinant_macros.svh"
module mi3_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mi3_pkg::req_type req_word,
   input logic             rsp_strobe,
   input mi3_pkg::rsp_type rsp_word
);
   localparam int LAT = 42;

   logic taken;
   logic inv_zero;

   assign taken    = start && !busy && (req_word == req_word);
   assign inv_zero = (rsp_word.inv00 == 0) && (rsp_word.inv01 == 0) &&
                     (rsp_word.inv02 == 0) && (rsp_word.inv10 == 0) &&
                     (rsp_word.inv11 == 0) && (rsp_word.inv12 == 0) &&
                     (rsp_word.inv20 == 0) && (rsp_word.inv21 == 0) &&
                     (rsp_word.inv22 == 0) && (rsp_word.det_value == 0);

   `MI3_ASSERT_IMPLY(a_singular_zero, rsp_strobe && rsp_word.singular, inv_zero)
   `MI3_ASSERT_SEQ(a_word_returns, taken, ##LAT rsp_strobe)
   `MI3_ASSERT_SEQ(a_no_spurious, rsp_strobe, $past(taken, LAT))
endmodule

bind matrix3x3_inverse_determinant mi3_checker u_checker (.*);
`default_nettype wire
